// File: rtl/rational_arithmetic_unit_macros.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked every clock, quiet in reset
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rau_pkg
// shared constants and types of the rational arithmetic unit
// ------------------------------------------------------------------------
package rau_pkg;
	localparam int DEF_WIDTH = 32;
	localparam int MAG_W     = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;
	localparam logic [2:0] OP_RED = 3'd5;

	// shared unit commands
	localparam logic [1:0] CMD_DIV = 2'd0;
	localparam logic [1:0] CMD_MUL = 2'd1;

	typedef struct packed {
		logic       go;
		logic [1:0] cmd;
	} alu_ctl_t;
endpackage

// File: rtl/rau_alu.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rau_alu
// shared 64-bit multicycle unit: restoring divide or shift-add multiply,
// one bit per cycle
// ------------------------------------------------------------------------
module rau_alu
	import rau_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  alu_ctl_t         ctl,
	input  logic [MAG_W-1:0] x,
	input  logic [MAG_W-1:0] y,
	output logic             done,
	output logic [MAG_W-1:0] quo,
	output logic [MAG_W-1:0] rem
);
	logic             busy_q;
	logic [1:0]       cmd_q;
	logic [6:0]       cnt_q;
	logic [MAG_W-1:0] a_q, b_q, r_q;
	logic [MAG_W:0]   trial;
	logic [MAG_W-1:0] rsh;

	assign rsh   = {r_q[MAG_W-2:0], a_q[MAG_W-1]};
	assign trial = {1'b0, rsh} - {1'b0, b_q};
	assign quo   = a_q;
	assign rem   = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			cmd_q <= ctl.cmd;
			a_q   <= x;
			b_q   <= y;
			r_q   <= '0;
		end else if (busy_q) begin
			if (cmd_q == CMD_DIV) begin
				// restoring division step, quotient shifts into a
				if (!trial[MAG_W]) begin
					r_q <= trial[MAG_W-1:0];
					a_q <= {a_q[MAG_W-2:0], 1'b1};
				end else begin
					r_q <= rsh;
					a_q <= {a_q[MAG_W-2:0], 1'b0};
				end
			end else begin
				// product in r, multiplier consumed lsb first
				if (a_q[0]) r_q <= r_q + b_q;
				a_q <= a_q >> 1;
				b_q <= b_q << 1;
			end
		end
	end
endmodule

// File: rtl/rau_seq.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rau_seq
// sequencer: walks one request through the shared unit
// ------------------------------------------------------------------------
module rau_seq
	import rau_pkg::*;
#(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       op,
	input  logic [31:0]      a_num,
	input  logic [31:0]      a_den,
	input  logic [31:0]      b_num,
	input  logic [31:0]      b_den,
	output logic             busy,
	output logic             done,
	output logic [31:0]      res_num,
	output logic [31:0]      res_den,
	output logic             is_equal,
	output logic             is_less,
	output logic             overflow,
	output alu_ctl_t         ctl,
	output logic [MAG_W-1:0] ax,
	output logic [MAG_W-1:0] ay,
	input  logic             adone,
	input  logic [MAG_W-1:0] aq,
	input  logic [MAG_W-1:0] ar
);
	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

	localparam logic [4:0] S_IDLE = 5'd0, S_G1 = 5'd1, S_G1W = 5'd2,
		S_L1 = 5'd3, S_L1W = 5'd4, S_L2 = 5'd5, S_L2W = 5'd6,
		S_M1 = 5'd7, S_M1W = 5'd8, S_M2 = 5'd9, S_M2W = 5'd10,
		S_SUM = 5'd11, S_G2 = 5'd12, S_G2W = 5'd13, S_D1 = 5'd14,
		S_D1W = 5'd15, S_D2 = 5'd16, S_D2W = 5'd17, S_OUT = 5'd18,
		S_ZERO = 5'd19, S_MD = 5'd20, S_MDW = 5'd21;

	logic [4:0]       st_q, ret_q;
	logic [2:0]       op_q;
	logic             an_q, bn_q, rn_q;
	logic [MAG_W-1:0] anm_q, adm_q, bnm_q, bdm_q;
	logic [MAG_W-1:0] gx_q, gy_q, gtog_q, t0_q, t1_q, rnum_q, rden_q;
	logic [MAG_W-1:0] wmask;

	function automatic logic [MAG_W-1:0] mag(input logic [31:0] raw,
		input logic [MAG_W-1:0] msk, output logic neg);
		logic [MAG_W-1:0] v;
		v   = {32'd0, raw} & msk;
		neg = v[WIDTH-1];
		return neg ? ((MAG_W'(1) << WIDTH) - v) : v;
	endfunction

	function automatic logic [31:0] enc(input logic neg,
		input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0] v;
		logic [31:0]      o;
		v = neg ? (MAG_W'(0) - m) : m;
		o = v[31:0];
		for (int i = WIDTH; i < 32; i++) o[i] = v[WIDTH-1];
		return o;
	endfunction

	assign wmask = (MAG_W'(1) << WIDTH) - MAG_W'(1);
	assign busy  = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			ctl  <= '0;
		end else begin
			done   <= 1'b0;
			ctl.go <= 1'b0;
			case (st_q)
				S_IDLE: if (start) st_q <= S_G1;
				// gcd of denominators (or skip straight to the op)
				S_G1: begin
					case (op_q)
						OP_ADD, OP_SUB: begin
							gx_q <= adm_q; gy_q <= bdm_q;
							ret_q <= S_L1; st_q <= S_G1W;
						end
						OP_MUL: begin
							rn_q <= an_q ^ bn_q;
							ax <= anm_q; ay <= bnm_q; t1_q <= bdm_q;
							ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_MDW;
						end
						OP_DIV: begin
							rn_q <= an_q ^ bn_q;
							ax <= anm_q; ay <= bdm_q;
							t1_q <= (bnm_q == '0) ? MAG_W'(1) : bnm_q;
							ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_MDW;
						end
						OP_CMP: begin
							ax <= anm_q; ay <= bdm_q;
							ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_MDW;
							t1_q <= '0;
						end
						OP_RED: begin
							rn_q <= an_q; rnum_q <= anm_q; rden_q <= adm_q;
							st_q <= S_ZERO;
						end
						default: begin
							res_num <= '0; res_den <= 32'd1; is_equal <= 1'b0;
							is_less <= 1'b0; overflow <= 1'b0;
							done <= 1'b1; st_q <= S_IDLE;
						end
					endcase
				end
				// gcd loop: x==0 -> y; y==0 -> x; else y%=x; swap roles
				S_G1W: begin
					if (gx_q == '0) begin
						gtog_q <= gy_q; st_q <= ret_q;
					end else if (gy_q == '0) begin
						gtog_q <= gx_q; st_q <= ret_q;
					end else begin
						ax <= gy_q; ay <= gx_q;
						ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_G2W;
					end
				end
				S_G2W: if (adone) begin
					gy_q <= gx_q; gx_q <= ar; st_q <= S_G1W;
				end
				// lcm = (ad/g)*bd
				S_L1: begin
					ax <= adm_q; ay <= gtog_q;
					ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_L1W;
				end
				S_L1W: if (adone) begin
					ax <= aq; ay <= bdm_q;
					ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_L2W;
				end
				S_L2W: if (adone) begin
					rden_q <= ar;
					ax <= ar; ay <= adm_q;
					ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_M1;
				end
				S_M1: if (adone) begin
					ax <= anm_q; ay <= aq;
					ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_M1W;
				end
				S_M1W: if (adone) begin
					t0_q <= ar;
					ax <= rden_q; ay <= bdm_q;
					ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_M2;
				end
				S_M2: if (adone) begin
					ax <= bnm_q; ay <= aq;
					ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_M2W;
				end
				S_M2W: if (adone) begin
					t1_q <= ar; st_q <= S_SUM;
				end
				S_SUM: begin
					// signed-magnitude add, subtract flips b
					if (an_q == (bn_q ^ (op_q == OP_SUB))) begin
						rnum_q <= t0_q + t1_q; rn_q <= an_q;
					end else if (t0_q >= t1_q) begin
						rnum_q <= t0_q - t1_q; rn_q <= an_q;
					end else begin
						rnum_q <= t1_q - t0_q; rn_q <= ~an_q;
					end
					st_q <= S_ZERO;
				end
				// two products: numerator then denominator, or for compare the two cross products
				S_MDW: if (adone) begin
					t0_q <= ar;
					ax <= (op_q == OP_CMP) ? bnm_q : adm_q;
					ay <= (op_q == OP_CMP) ? adm_q : t1_q;
					ctl <= '{go: 1'b1, cmd: CMD_MUL}; st_q <= S_MD;
				end
				S_MD: if (adone) begin
					if (op_q == OP_CMP) begin
						res_num <= '0; res_den <= 32'd1; overflow <= 1'b0;
						if ((an_q && t0_q != '0) != (bn_q && ar != '0)) begin
							is_equal <= 1'b0; is_less <= an_q && t0_q != '0;
						end else if (t0_q == ar) begin
							is_equal <= 1'b1; is_less <= 1'b0;
						end else begin
							is_equal <= 1'b0;
							is_less <= (t0_q < ar) ^ (an_q && t0_q != '0);
						end
						done <= 1'b1; st_q <= S_IDLE;
					end else begin
						rnum_q <= t0_q; rden_q <= ar; st_q <= S_ZERO;
					end
				end
				// reduction
				S_ZERO: begin
					if (rnum_q == '0) begin
						rn_q <= 1'b0; rden_q <= MAG_W'(1); st_q <= S_OUT;
					end else begin
						gx_q <= rnum_q; gy_q <= rden_q; ret_q <= S_D1; st_q <= S_G1W;
					end
				end
				S_D1: begin
					ax <= rnum_q; ay <= gtog_q;
					ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_D1W;
				end
				S_D1W: if (adone) begin
					rnum_q <= aq;
					ax <= rden_q; ay <= gtog_q;
					ctl <= '{go: 1'b1, cmd: CMD_DIV}; st_q <= S_D2W;
				end
				S_D2W: if (adone) begin
					rden_q <= aq; st_q <= S_OUT;
				end
				S_OUT: begin
					res_num  <= enc(rn_q, rnum_q);
					res_den  <= enc(1'b0, rden_q);
					is_equal <= 1'b0; is_less <= 1'b0;
					overflow <= (rden_q > LIM - MAG_W'(1)) ||
						(rnum_q > (rn_q ? LIM : LIM - MAG_W'(1)));
					done <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		logic nn, dn, bnn, bdn;
		logic [MAG_W-1:0] n, d, bnv, bdv;
		if (st_q == S_IDLE && start) begin
			n   = mag(a_num, wmask, nn);
			d   = mag(a_den, wmask, dn);
			bnv = mag(b_num, wmask, bnn);
			bdv = mag(b_den, wmask, bdn);
			if (d == '0) begin d = MAG_W'(1); dn = 1'b0; end
			if (bdv == '0) begin bdv = MAG_W'(1); bdn = 1'b0; end
			op_q  <= op;
			anm_q <= n;   adm_q <= d;   an_q <= (n != '0) && (nn != dn);
			bnm_q <= bnv; bdm_q <= bdv; bn_q <= (bnv != '0) && (bnn != bdn);
		end
	end
endmodule

// File: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rational_arithmetic_unit
// signed fraction add/sub/mul/div/compare/reduce with gcd reduction
// ------------------------------------------------------------------------
// pulse start while busy is low; the request is taken on that edge and busy
// stays high until the result is out. done is high for exactly one cycle
// with the result, which then holds until the next one, so capture it then.
// all work runs through one 64-bit unit that divides or multiplies one bit per
// cycle; each euclid step of a gcd run is one divide. compare uses two
// multiplies, reduce a gcd run and two divides (none if the numerator is zero),
// multiply and divide two multiplies and then the reduction, and add and
// subtract a gcd run of the denominators, then divides and multiplies for the
// lcm and both numerators, then the reduction with its gcd run. the number of
// euclid steps depends on the operands.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        done,
	output logic [31:0] res_num,
	output logic [31:0] res_den,
	output logic        is_equal,
	output logic        is_less,
	output logic        overflow
);
	// shared unit hookup
	alu_ctl_t         ctl;
	logic [MAG_W-1:0] ax, ay, aq, ar;
	logic             adone;

	rau_seq #(.WIDTH(WIDTH)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.busy(busy), .done(done), .res_num(res_num), .res_den(res_den),
		.is_equal(is_equal), .is_less(is_less), .overflow(overflow),
		.ctl(ctl), .ax(ax), .ay(ay), .adone(adone), .aq(aq), .ar(ar)
	);

	rau_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .x(ax), .y(ay),
		.done(adone), .quo(aq), .rem(ar)
	);
endmodule

// File: rtl/rau_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// rau_checker
// port-level checks of the rational arithmetic unit
// ------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] res_den,
	input logic        is_equal,
	input logic        is_less,
	input logic        overflow
);
	`RAU_ASSERT_NXT(a_take, clk, arst_n, start && !busy, busy, "request not taken")
	`RAU_ASSERT_IMP(a_drop, clk, arst_n, done, !busy, "busy after result")
	`RAU_ASSERT_IMP(a_flags, clk, arst_n, done, !(is_equal && is_less), "equal and less")
	`RAU_ASSERT_IMP(a_den, clk, arst_n, done && !overflow, !res_den[31] && res_den != 32'd0, "bad denominator")
endmodule

bind rational_arithmetic_unit rau_checker u_chk (.*);
